/* sv/tepp_pkg.sv */
// shared types and constants of the timestamp event pairing block
`timescale 1ns / 1ps

package tepp_pkg;

  // holding queue geometry
  localparam int QUEUE_DEPTH = 32;
  localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W       = QIDX_W + 1;

  // request buffer between front and back
  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_IDX_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  // tail fraction arithmetic
  localparam int SCALE_W     = 14;
  localparam int DIFF_W      = 33;
  localparam int PROD_W      = DIFF_W + SCALE_W + 1;
  localparam int STEP_W      = $clog2(PROD_W + 1);
  localparam logic signed [SCALE_W:0] TAIL_SCALE = (SCALE_W + 1)'(10000);
  localparam logic [PROD_W-1:0] POS_LIMIT = PROD_W'(64'h0000_0000_7fff_ffff);
  localparam logic [PROD_W-1:0] NEG_LIMIT = PROD_W'(64'h0000_0000_8000_0000);
  localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  // event sources
  localparam logic SRC_CHARGE = 1'b0;
  localparam logic SRC_SHAPE  = 1'b1;

  // classified event: first word is short or length, second is long or width
  typedef struct packed {
    logic        src;
    logic [63:0] stamp;
    logic [31:0] first_word;
    logic [31:0] second_word;
  } evt_item_t;

endpackage

/* sv/tepp_evt_if.sv */
// event input channel
`timescale 1ns / 1ps

interface tepp_evt_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [63:0]        event_time;
  logic signed [31:0] charge_short;
  logic signed [31:0] charge_long;
  logic [31:0]        shape_length;
  logic [31:0]        shape_width;

  modport source (
    output valid, opcode, event_time, charge_short, charge_long, shape_length, shape_width,
    input  ready
  );
  modport sink (
    input  valid, opcode, event_time, charge_short, charge_long, shape_length, shape_width,
    output ready
  );
endinterface

/* sv/tepp_pair_if.sv */
// paired result output channel
`timescale 1ns / 1ps

interface tepp_pair_if;
  logic               valid;
  logic               ready;
  logic [63:0]        pair_time;
  logic [31:0]        pair_length;
  logic [31:0]        pair_width;
  logic signed [31:0] pair_short;
  logic signed [31:0] pair_long;
  logic signed [31:0] tail_fraction;
  logic [31:0]        pairs_total;
  logic [31:0]        charge_dropped_total;
  logic [31:0]        shape_dropped_total;
  logic [31:0]        lost_full_total;

  modport source (
    output valid, pair_time, pair_length, pair_width, pair_short, pair_long, tail_fraction,
           pairs_total, charge_dropped_total, shape_dropped_total, lost_full_total,
    input  ready
  );
  modport sink (
    input  valid, pair_time, pair_length, pair_width, pair_short, pair_long, tail_fraction,
           pairs_total, charge_dropped_total, shape_dropped_total, lost_full_total,
    output ready
  );
endinterface

/* sv/tepp_front.sv */
// front end: accepts events, picks the words of their source, buffers them
`timescale 1ns / 1ps

module tepp_front import tepp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  tepp_evt_if.sink   evt,
  output evt_item_t  item,
  output logic       item_valid,
  input  logic       item_pop
);

  evt_item_t             fifo_mem [FIFO_DEPTH];
  logic [FIFO_IDX_W-1:0] wr_ptr;
  logic [FIFO_IDX_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] fill;
  evt_item_t             item_in;
  logic                  push;
  logic                  pop;

  // classify the incoming request by source
  always_comb begin
    item_in.src   = evt.opcode;
    item_in.stamp = evt.event_time;
    if (evt.opcode == SRC_SHAPE) begin
      item_in.first_word  = evt.shape_length;
      item_in.second_word = evt.shape_width;
    end else begin
      item_in.first_word  = evt.charge_short;
      item_in.second_word = evt.charge_long;
    end
  end

  assign evt.ready  = (fill != FIFO_CNT_W'(FIFO_DEPTH));
  assign push       = evt.valid && evt.ready;
  assign item_valid = (fill != '0);
  assign pop        = item_pop && item_valid;
  assign item       = fifo_mem[rd_ptr];

  // buffer storage
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= item_in;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == FIFO_IDX_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == FIFO_IDX_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

/* sv/tepp_divider.sv */
// restoring radix-2 divider, one quotient bit per cycle
`timescale 1ns / 1ps

module tepp_divider import tepp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [31:0]       divisor,
  output logic              done,
  output logic [PROD_W-1:0] quotient
);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [30:0]       rem;
  logic [31:0]       dsr;
  logic [PROD_W-1:0] quo_sh;
  logic [31:0]       trial;
  logic              fits;

  // one trial subtraction
  assign trial    = {rem, quo_sh[PROD_W-1]};
  assign fits     = (trial >= dsr);
  assign quotient = quo_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(PROD_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: dividend shifts out at the top, quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= '0;
      dsr    <= divisor;
      quo_sh <= dividend;
    end else if (busy) begin
      rem    <= fits ? 31'(trial - dsr) : trial[30:0];
      quo_sh <= {quo_sh[PROD_W-2:0], fits};
    end
  end

endmodule

/* sv/tepp_back.sv */
// back end: holding queue, timestamp matching, tail fraction and result register
`timescale 1ns / 1ps

module tepp_back import tepp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  evt_item_t   item,
  input  logic        item_valid,
  output logic        item_pop,
  tepp_pair_if.source pair
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_DECIDE  = 3'd1;
  localparam logic [2:0] ST_COMPARE = 3'd2;
  localparam logic [2:0] ST_MUL     = 3'd3;
  localparam logic [2:0] ST_START   = 3'd4;
  localparam logic [2:0] ST_DIV     = 3'd5;
  localparam logic [2:0] ST_DONE    = 3'd6;

  logic [2:0]        state;
  evt_item_t         cur;
  logic [QIDX_W-1:0] head;
  logic [QCNT_W-1:0] count;
  logic              held_source;
  logic [31:0]       pair_counter;
  logic [31:0]       charge_drop_counter;
  logic [31:0]       shape_drop_counter;
  logic [31:0]       full_loss_counter;

  // holding queue memory
  logic [63:0]       q_stamp  [QUEUE_DEPTH];
  logic [31:0]       q_first  [QUEUE_DEPTH];
  logic [31:0]       q_second [QUEUE_DEPTH];
  logic [63:0]       rd_stamp;
  logic [31:0]       rd_first;
  logic [31:0]       rd_second;

  // pair payload in flight
  logic [63:0]        p_stamp;
  logic [31:0]        p_length;
  logic [31:0]        p_width;
  logic signed [31:0] p_short;
  logic signed [31:0] p_long;
  logic signed [PROD_W-1:0] product;
  logic               neg;
  logic [31:0]        tail;

  // result register
  logic               out_valid;
  logic               out_load;
  logic [63:0]        out_stamp;
  logic [31:0]        out_length;
  logic [31:0]        out_width;
  logic [31:0]        out_short;
  logic [31:0]        out_long;
  logic [31:0]        out_tail;
  logic [31:0]        out_pairs;
  logic [31:0]        out_charge_drops;
  logic [31:0]        out_shape_drops;
  logic [31:0]        out_lost;

  logic [SUM_W-1:0]   tail_sum;
  logic [QIDX_W-1:0]  tail_idx;
  logic [QIDX_W-1:0]  head_inc;
  logic               append;
  logic               q_full;
  logic               q_write;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod_c;
  logic [PROD_W-1:0]  mag;
  logic               div_done;
  logic [PROD_W-1:0]  quotient;
  logic [31:0]        tail_sat;

  // queue addressing
  assign tail_sum = SUM_W'(head) + SUM_W'(count);
  assign tail_idx = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                    QIDX_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : QIDX_W'(tail_sum);
  assign head_inc = (head == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
  assign append   = (count == '0) || (held_source == cur.src);
  assign q_full   = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_write  = (state == ST_DECIDE) && append && !q_full;

  assign item_pop = (state == ST_IDLE) && item_valid;

  // result register takes a new pair when empty or being drained
  assign out_load = (state == ST_DONE) && (!out_valid || pair.ready);

  // tail fraction numerator and its magnitude
  assign diff   = {p_long[31], p_long} - {p_short[31], p_short};
  assign prod_c = diff * TAIL_SCALE;
  assign mag    = neg ? PROD_W'(-product) : PROD_W'(product);

  // saturate the signed quotient to 32 bits
  always_comb begin
    if (!neg) begin
      tail_sat = (quotient > POS_LIMIT) ? SAT_MAX : quotient[31:0];
    end else begin
      tail_sat = (quotient > NEG_LIMIT) ? SAT_MIN : 32'(-quotient);
    end
  end

  tepp_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_START),
    .dividend (mag),
    .divisor  (p_long),
    .done     (div_done),
    .quotient (quotient)
  );

  // queue write port and registered read of the head
  always_ff @(posedge clk) begin
    if (q_write) begin
      q_stamp[tail_idx]  <= cur.stamp;
      q_first[tail_idx]  <= cur.first_word;
      q_second[tail_idx] <= cur.second_word;
    end
    rd_stamp  <= q_stamp[head];
    rd_first  <= q_first[head];
    rd_second <= q_second[head];
  end

  // sequencer and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= ST_IDLE;
      head                <= '0;
      count               <= '0;
      held_source         <= SRC_CHARGE;
      pair_counter        <= '0;
      charge_drop_counter <= '0;
      shape_drop_counter  <= '0;
      full_loss_counter   <= '0;
      out_valid           <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pair.valid && pair.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (item_valid) begin
            cur   <= item;
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (append) begin
            if (q_full) begin
              full_loss_counter <= full_loss_counter + 1'b1;
            end else begin
              held_source <= cur.src;
              count       <= count + 1'b1;
            end
            state <= ST_IDLE;
          end else begin
            state <= ST_COMPARE;
          end
        end
        ST_COMPARE: begin
          if (rd_stamp == cur.stamp) begin
            head         <= head_inc;
            count        <= count - 1'b1;
            pair_counter <= pair_counter + 1'b1;
            p_stamp      <= cur.stamp;
            if (cur.src == SRC_SHAPE) begin
              p_short  <= $signed(rd_first);
              p_long   <= $signed(rd_second);
              p_length <= cur.first_word;
              p_width  <= cur.second_word;
            end else begin
              p_short  <= $signed(cur.first_word);
              p_long   <= $signed(cur.second_word);
              p_length <= rd_first;
              p_width  <= rd_second;
            end
            state <= ST_MUL;
          end else if (rd_stamp < cur.stamp) begin
            // head is older: drop it and look at the next one
            if (held_source == SRC_SHAPE) begin
              shape_drop_counter <= shape_drop_counter + 1'b1;
            end else begin
              charge_drop_counter <= charge_drop_counter + 1'b1;
            end
            head  <= head_inc;
            count <= count - 1'b1;
            state <= ST_DECIDE;
          end else begin
            // new event is older: drop it
            if (cur.src == SRC_SHAPE) begin
              shape_drop_counter <= shape_drop_counter + 1'b1;
            end else begin
              charge_drop_counter <= charge_drop_counter + 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        ST_MUL: begin
          if (p_long <= 0) begin
            tail  <= '0;
            state <= ST_DONE;
          end else begin
            product <= prod_c;
            neg     <= prod_c[PROD_W-1];
            state   <= ST_START;
          end
        end
        ST_START: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            tail  <= tail_sat;
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            out_stamp        <= p_stamp;
            out_length       <= p_length;
            out_width        <= p_width;
            out_short        <= p_short;
            out_long         <= p_long;
            out_tail         <= tail;
            out_pairs        <= pair_counter;
            out_charge_drops <= charge_drop_counter;
            out_shape_drops  <= shape_drop_counter;
            out_lost         <= full_loss_counter;
            state            <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result channel
  assign pair.valid                = out_valid;
  assign pair.pair_time            = out_stamp;
  assign pair.pair_length          = out_length;
  assign pair.pair_width           = out_width;
  assign pair.pair_short           = $signed(out_short);
  assign pair.pair_long            = $signed(out_long);
  assign pair.tail_fraction        = $signed(out_tail);
  assign pair.pairs_total          = out_pairs;
  assign pair.charge_dropped_total = out_charge_drops;
  assign pair.shape_dropped_total  = out_shape_drops;
  assign pair.lost_full_total      = out_lost;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("holding queue count above depth");

  a_pair_on_match: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && pair_counter != $past(pair_counter)) |-> $past(state) == ST_COMPARE)
    else $error("pair counter moved outside a timestamp match");

  a_load_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result register loaded outside the done step");

  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished while the sequencer was not waiting");

endmodule

/* sv/timestamp_event_pairing_psd_top.sv */
// top level of the timestamp event pairing block with tail fraction
`timescale 1ns / 1ps

// Pairs charge-integration events with shape-analysis events of equal timestamp.
// Requests enter a two-entry buffer that takes a new event every cycle while it has
// room, so the input keeps flowing while the back end works. The back end handles one
// event at a time: an event queued or lost on a full queue passes the idle and decide
// steps, one dropped as older than the queue head the compare step too; each older queue
// head discarded adds a decide step (registered read of the holding queue memory) and a
// compare step. A match runs the multiply step and, with the 48-step radix-2 divider
// forming the tail fraction, start and divide (skipped if the long integral is <= 0);
// the result then waits in an output register while the next event is processed.

module timestamp_event_pairing_psd_top import tepp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  tepp_evt_if.sink    evt,
  tepp_pair_if.source pair
);

  evt_item_t item;
  logic      item_valid;
  logic      item_pop;

  tepp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .evt        (evt),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop)
  );

  tepp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop),
    .pair       (pair)
  );

endmodule
